// ===== rtl/bcrb_pkg.sv =====
// Shared types and constants for the block capture ring buffer.
// No dependencies; used by bcrb_ctrl, bcrb_dpath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bcrb_pkg;

  // default geometry
  localparam int SLOTS_DEF    = 8;
  localparam int CAPACITY_DEF = 1024;

  // channel widths
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 120;

  // command codes carried on in_tuser
  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_READ    = 3'd1,
    CMD_CONSUME = 3'd2,
    CMD_START   = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_DEV_ERR = 3'd5
  } cmd_t;

  // sticky failure codes
  localparam logic [1:0] FAIL_NONE   = 2'd0;
  localparam logic [1:0] FAIL_BLOCK  = 2'd1;
  localparam logic [1:0] FAIL_FULL   = 2'd2;
  localparam logic [1:0] FAIL_DEVICE = 2'd3;

  // controller -> datapath strobes
  typedef struct packed {
    logic load;       // latch the accepted request
    logic exec;       // apply the request to the ring state
    logic len_rd;     // read length of the head block
    logic resp_load;  // load the result register
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/bcrb_ctrl.sv =====
// Sequencing controller: one request at a time through execute, length read and result.
// Depends on bcrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcrb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output bcrb_pkg::ctrl_t      ctrl
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_LEN  = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    ctrl           = '0;
    in_tready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.load = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.exec = 1'b1;
        state_nxt = ST_LEN;
      end
      ST_LEN: begin
        ctrl.len_rd = 1'b1;
        state_nxt   = ST_RESP;
      end
      ST_RESP: begin
        // wait for the result register to drain
        if (!out_valid_r || out_tready) begin
          ctrl.resp_load = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (ctrl.resp_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/bcrb_dpath.sv =====
// Datapath: ring pointers, block assembly state, status flags, sample and length
// memories, and the result register. Depends on bcrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcrb_dpath #(
  parameter int SLOTS    = bcrb_pkg::SLOTS_DEF,
  parameter int CAPACITY = bcrb_pkg::CAPACITY_DEF,
  localparam int PW      = $clog2(2 * SLOTS)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire bcrb_pkg::ctrl_t                    ctrl,
  input  wire logic [bcrb_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic [bcrb_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  wire logic                               in_tlast,
  output logic      [bcrb_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic      [1:0]                         failure_o,
  output logic      [PW-1:0]                      held_o
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW    = $clog2(CAPACITY + 2);
  localparam int LW    = $clog2(CAPACITY + 1);
  localparam int OW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DEPTH = SLOTS * CAPACITY;
  localparam int AW    = $clog2(DEPTH);

  // latched request
  bcrb_pkg::cmd_t cmd_r;
  logic [31:0]    sample_r;
  logic           has_r;
  logic           last_r;
  logic           bval_r;
  logic [9:0]     idx_r;
  logic [31:0]    dcode_r;

  // ring and block state
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic          accepting_r, accepting_nxt;
  logic [1:0]    failure_r, failure_nxt;
  logic          received_r, received_nxt;
  logic [31:0]   deliveries_r, deliveries_nxt;
  logic [31:0]   dev_code_r, dev_code_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          open_r, open_nxt;
  logic          bcapt_r, bcapt_nxt;
  logic          bvalid_r, bvalid_nxt;

  // memories
  logic [31:0]   sample_mem [DEPTH];
  logic [LW-1:0] length_mem [SLOTS];
  logic [31:0]   sample_rd_r;
  logic [LW-1:0] length_rd_r;
  logic [bcrb_pkg::OUT_TDATA_W-1:0] out_r, out_nxt;

  // derived
  logic [PW:0]   held_w;
  logic [PW-1:0] held;
  logic [PW-1:0] wslot_w, rslot_w;
  logic [SW-1:0] wslot, rslot;
  logic [31:0]   idx_ext;
  logic          idx_in_cap;
  logic          first_item;
  logic          valid_eff, capt_eff;
  logic [FW-1:0] fill0, fill1;
  logic          smem_we, smem_re, lmem_we;
  logic [SW-1:0] slot_sel;
  logic [OW-1:0] off_sel;
  logic [AW-1:0] smem_addr;

  always_comb begin
    if (wp_r >= rp_r) begin
      held_w = {1'b0, wp_r} - {1'b0, rp_r};
    end else begin
      held_w = {1'b0, wp_r} + (PW + 1)'(2 * SLOTS) - {1'b0, rp_r};
    end
    held    = held_w[PW-1:0];
    wslot_w = (wp_r >= PW'(SLOTS)) ? wp_r - PW'(SLOTS) : wp_r;
    rslot_w = (rp_r >= PW'(SLOTS)) ? rp_r - PW'(SLOTS) : rp_r;
    wslot   = wslot_w[SW-1:0];
    rslot   = rslot_w[SW-1:0];
    idx_ext    = 32'(idx_r);
    idx_in_cap = (idx_ext < 32'(CAPACITY));
  end

  // push-item bookkeeping
  always_comb begin
    first_item = !open_r;
    valid_eff  = first_item ? bval_r : bvalid_r;
    capt_eff   = first_item ? (accepting_r && (failure_r == bcrb_pkg::FAIL_NONE)) : bcapt_r;
    fill0      = first_item ? '0 : fill_r;
    if (has_r && (fill0 <= FW'(CAPACITY))) begin
      fill1 = fill0 + FW'(1);
    end else begin
      fill1 = fill0;
    end
  end

  // request execution
  always_comb begin
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    accepting_nxt  = accepting_r;
    failure_nxt    = failure_r;
    received_nxt   = received_r;
    deliveries_nxt = deliveries_r;
    dev_code_nxt   = dev_code_r;
    fill_nxt       = fill_r;
    open_nxt       = open_r;
    bcapt_nxt      = bcapt_r;
    bvalid_nxt     = bvalid_r;
    smem_we        = 1'b0;
    smem_re        = 1'b0;
    lmem_we        = 1'b0;
    if (ctrl.exec) begin
      unique case (cmd_r)
        bcrb_pkg::CMD_PUSH: begin
          smem_we = has_r && capt_eff && (fill0 < FW'(CAPACITY)) && (held < PW'(SLOTS));
          if (last_r) begin
            if (valid_eff && (fill1 != '0)) begin
              received_nxt   = 1'b1;
              deliveries_nxt = deliveries_r + 32'd1;
            end
            if (capt_eff && (failure_r == bcrb_pkg::FAIL_NONE)) begin
              priority if (!valid_eff || (fill1 > FW'(CAPACITY))) begin
                failure_nxt = bcrb_pkg::FAIL_BLOCK;
              end else if (held >= PW'(SLOTS)) begin
                failure_nxt = bcrb_pkg::FAIL_FULL;
              end else begin
                lmem_we = 1'b1;
                wp_nxt  = (wp_r == PW'(2 * SLOTS - 1)) ? '0 : wp_r + PW'(1);
              end
            end
            open_nxt   = 1'b0;
            bcapt_nxt  = 1'b0;
            bvalid_nxt = 1'b0;
            fill_nxt   = '0;
          end else begin
            open_nxt   = 1'b1;
            bcapt_nxt  = capt_eff;
            bvalid_nxt = valid_eff;
            fill_nxt   = fill1;
          end
        end
        bcrb_pkg::CMD_READ: begin
          smem_re = (held != '0) && idx_in_cap;
        end
        bcrb_pkg::CMD_CONSUME: begin
          if (held != '0) begin
            rp_nxt = (rp_r == PW'(2 * SLOTS - 1)) ? '0 : rp_r + PW'(1);
          end
        end
        bcrb_pkg::CMD_START: accepting_nxt = 1'b1;
        bcrb_pkg::CMD_STOP:  accepting_nxt = 1'b0;
        bcrb_pkg::CMD_DEV_ERR: begin
          dev_code_nxt = dcode_r;
          if (failure_r == bcrb_pkg::FAIL_NONE) begin
            failure_nxt = bcrb_pkg::FAIL_DEVICE;
          end
        end
        default: ;
      endcase
    end
  end

  // one sample-memory port, shared by push writes and reads
  always_comb begin
    slot_sel  = (cmd_r == bcrb_pkg::CMD_READ) ? rslot : wslot;
    off_sel   = (cmd_r == bcrb_pkg::CMD_READ) ? idx_ext[OW-1:0] : fill0[OW-1:0];
    smem_addr = AW'(AW'(slot_sel) * AW'(CAPACITY)) + AW'(off_sel);
  end

  always_ff @(posedge clk) begin
    if (smem_we) begin
      sample_mem[smem_addr] <= sample_r;
    end
    if (smem_re) begin
      sample_rd_r <= sample_mem[smem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lmem_we) begin
      length_mem[wslot] <= fill1[LW-1:0];
    end
    if (ctrl.len_rd) begin
      length_rd_r <= length_mem[rslot];
    end
  end

  // result assembly, status after the request
  logic [31:0] len_ext, held_ext, rdata;
  logic        ready;
  always_comb begin
    ready    = (held != '0);
    len_ext  = ready ? 32'(length_rd_r) : 32'd0;
    held_ext = 32'(held);
    if ((cmd_r == bcrb_pkg::CMD_READ) && ready && idx_in_cap &&
        (idx_ext < 32'(length_rd_r))) begin
      rdata = sample_rd_r;
    end else begin
      rdata = 32'd0;
    end
    out_nxt = {4'b0000, held_ext[3:0], accepting_r, dev_code_r, deliveries_r,
               received_r, failure_r, len_ext[10:0], ready, rdata};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r    <= bcrb_pkg::cmd_t'(in_tuser);
      sample_r <= in_tdata[31:0];
      has_r    <= in_tdata[32];
      bval_r   <= in_tdata[33];
      idx_r    <= in_tdata[43:34];
      dcode_r  <= in_tdata[75:44];
      last_r   <= in_tlast;
    end
    if (ctrl.resp_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      rp_r         <= '0;
      accepting_r  <= 1'b0;
      failure_r    <= bcrb_pkg::FAIL_NONE;
      received_r   <= 1'b0;
      deliveries_r <= '0;
      dev_code_r   <= '0;
      fill_r       <= '0;
      open_r       <= 1'b0;
      bcapt_r      <= 1'b0;
      bvalid_r     <= 1'b0;
    end else begin
      wp_r         <= wp_nxt;
      rp_r         <= rp_nxt;
      accepting_r  <= accepting_nxt;
      failure_r    <= failure_nxt;
      received_r   <= received_nxt;
      deliveries_r <= deliveries_nxt;
      dev_code_r   <= dev_code_nxt;
      fill_r       <= fill_nxt;
      open_r       <= open_nxt;
      bcapt_r      <= bcapt_nxt;
      bvalid_r     <= bvalid_nxt;
    end
  end

  assign out_tdata = out_r;
  assign failure_o = failure_r;
  assign held_o    = held;

endmodule

`default_nettype wire

// ===== rtl/block_capture_ring_buffer_core.sv =====
// Top level of the block capture ring buffer: controller plus datapath.
// Depends on bcrb_pkg, bcrb_ctrl and bcrb_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_*): one request per handshake; in_tuser selects the command
//   (push, read, consume, start, stop, device error), in_tlast closes a block.
//   Output channel (out_*): exactly one result per request, in request order,
//   carrying the read word and the ring status after the request.
// Timing
//   Accept -> execute -> head-length read -> result register: out_tvalid rises
//   once the result is loaded into a free result register. A new request is
//   taken only after the previous result is loaded; the bound is the sequencer
//   walking the single-port sample and registered length memories once per request.
// Reset
//   rst_n (synchronous, low) clears pointers, flags, failure, counters and the
//   open-block state. Sample and length memories are not cleared; only committed
//   blocks are ever read back.
// Stall
//   A finished result holds in the output register while out_tready is low; the
//   next request is still accepted, and its result waits in the sequencer until
//   the register drains.
module block_capture_ring_buffer_core #(
  parameter int SLOTS    = bcrb_pkg::SLOTS_DEF,
  parameter int CAPACITY = bcrb_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // sample[31:0], has_sample[32], block_valid[33], read_index[43:34],
  // device_code[75:44], zero[79:76]
  input  wire logic [bcrb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd[2:0]
  input  wire logic [bcrb_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // read_data[31:0], block_ready[32], block_length[43:33], failure[45:44],
  // received[46], delivery_count[78:47], device_status[110:79],
  // capturing[111], blocks_held[115:112], zero[119:116]
  output logic      [bcrb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int PW = $clog2(2 * SLOTS);

  bcrb_pkg::ctrl_t ctrl;
  logic [1:0]      failure_cur;
  logic [PW-1:0]   held_cur;

  bcrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl)
  );

  bcrb_dpath #(
    .SLOTS    (SLOTS),
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .failure_o (failure_cur),
    .held_o    (held_cur)
  );

  // one request in flight: the sequencer closes the input right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  // the first failure sticks until reset
  a_failure_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (failure_cur != bcrb_pkg::FAIL_NONE) |=> (failure_cur == $past(failure_cur)))
    else $error("latched failure changed");

  // the ring never holds more committed blocks than it has slots
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_cur <= PW'(SLOTS))
    else $error("ring holds more blocks than slots");

endmodule

`default_nettype wire
